>>> hdl/i2c_master_bit_engine_macros.svh
// Assertion macros shared by the engine's RTL.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define I2CBE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define I2CBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/i2cbe_pkg.sv
package i2cbe_pkg;

    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_STOP     = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_READ     = 3'd3,
        CMD_SEND_ACK = 3'd4,
        CMD_READ_ACK = 3'd5
    } t_cmd;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned IN_USER_W  = 4;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [7:0] MSB_MASK = 8'h80;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       ack_value;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_received;
    } t_result;

    typedef struct packed {
        logic       active;
        logic [4:0] slot;
    } t_core_status;

    function automatic logic [4:0] cmd_len(t_cmd c);
        logic [4:0] len;
        case (c)
            CMD_START:    len = 5'd4;
            CMD_STOP:     len = 5'd3;
            CMD_WRITE:    len = 5'd24;
            CMD_READ:     len = 5'd25;
            CMD_SEND_ACK: len = 5'd3;
            default:      len = 5'd4;
        endcase
        return len;
    endfunction

endpackage

>>> hdl/i2cbe_slot_core.sv
module i2cbe_slot_core
    import i2cbe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_advance,
    input  t_item        i_item,
    output t_result      o_result,
    output t_core_status o_status
);

    logic [4:0] r_slot,  n_slot;
    logic [1:0] r_phase, n_phase;
    t_cmd       r_cmd,   n_cmd;
    logic       r_active, n_active;
    logic [7:0] r_shift, n_shift;
    logic       r_ack_latch, n_ack_latch;
    logic       r_pend_ack,  n_pend_ack;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;

    logic       start;
    t_cmd       cmd;
    logic [4:0] slot;
    logic [1:0] phase;
    logic [1:0] rd_phase;
    logic       last;
    logic       done;

    always_comb begin
        start   = !r_active && i_item.cmd_valid && (i_item.func <= CMD_READ_ACK);
        cmd     = start ? t_cmd'(i_item.func) : r_cmd;
        slot    = start ? 5'd0 : r_slot;
        phase   = start ? 2'd0 : r_phase;
        n_shift = (start && (i_item.func == CMD_WRITE)) ? i_item.tx_byte : r_shift;
        n_pend_ack = (start && (i_item.func == CMD_SEND_ACK)) ? i_item.ack_value : r_pend_ack;
        n_cmd       = r_cmd;
        n_active    = r_active;
        n_slot      = r_slot;
        n_phase     = r_phase;
        n_ack_latch = r_ack_latch;
        n_scl       = r_scl;
        n_sda       = r_sda;
        last        = 1'b0;
        done        = 1'b0;

        case (phase)
            2'd0:    rd_phase = 2'd2;
            2'd1:    rd_phase = 2'd0;
            default: rd_phase = 2'd1;
        endcase

        if (r_active || start) begin
            n_cmd = cmd;
            case (cmd)
                CMD_START: begin
                    case (slot)
                        5'd0:    n_sda = 1'b1;
                        5'd1:    n_scl = 1'b1;
                        5'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                CMD_STOP: begin
                    case (slot)
                        5'd0:    n_sda = 1'b0;
                        5'd1:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                CMD_WRITE: begin
                    case (phase)
                        2'd0:    n_sda = |(n_shift & MSB_MASK);
                        2'd1:    n_scl = 1'b1;
                        default: begin
                            n_scl   = 1'b0;
                            n_shift = {n_shift[6:0], 1'b0};
                        end
                    endcase
                end
                CMD_READ: begin
                    if (slot == 5'd0) begin
                        n_sda   = 1'b1;
                        n_shift = 8'd0;
                    end else begin
                        case (rd_phase)
                            2'd0:    n_scl = 1'b1;
                            2'd1:    n_shift = {n_shift[6:0], i_item.sda_in};
                            default: n_scl = 1'b0;
                        endcase
                    end
                end
                CMD_SEND_ACK: begin
                    case (slot)
                        5'd0:    n_sda = n_pend_ack;
                        5'd1:    n_scl = 1'b1;
                        default: n_scl = 1'b0;
                    endcase
                end
                default: begin
                    case (slot)
                        5'd0:    n_sda = 1'b1;
                        5'd1:    n_scl = 1'b1;
                        5'd2:    n_ack_latch = i_item.sda_in;
                        default: n_scl = 1'b0;
                    endcase
                end
            endcase

            last = ({1'b0, slot} + 6'd1) >= {1'b0, cmd_len(cmd)};
            if (last) begin
                done     = 1'b1;
                n_active = 1'b0;
                n_slot   = 5'd0;
                n_phase  = 2'd0;
            end else begin
                n_active = 1'b1;
                n_slot   = slot + 5'd1;
                n_phase  = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
            end
        end

        o_result.scl_out      = n_scl;
        o_result.sda_out      = n_sda;
        o_result.busy_res     = n_active;
        o_result.done_res     = done;
        o_result.rx_byte      = (done && (cmd == CMD_READ)) ? n_shift : 8'd0;
        o_result.ack_received = done && (cmd == CMD_READ_ACK) && n_ack_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= 5'd0;
            r_phase     <= 2'd0;
            r_cmd       <= CMD_START;
            r_active    <= 1'b0;
            r_shift     <= 8'd0;
            r_ack_latch <= 1'b0;
            r_pend_ack  <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else if (i_advance) begin
            r_slot      <= n_slot;
            r_phase     <= n_phase;
            r_cmd       <= n_cmd;
            r_active    <= n_active;
            r_shift     <= n_shift;
            r_ack_latch <= n_ack_latch;
            r_pend_ack  <= n_pend_ack;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
        end
    end

    assign o_status.active = r_active;
    assign o_status.slot   = r_slot;

endmodule

>>> hdl/i2c_master_bit_engine.sv
// I2C master bit engine. Each transfer on the slave stream is one bus time slot and yields
// exactly one transfer on the master stream with the SCL/SDA drive levels after that slot,
// busy, done and any received byte or ack. One slot per clock is sustained: the slot is
// held in an input register, run through the command sequencer's combinational next-state
// logic, and the result lands in an output register, so a stalled master side blocks
// input only when both registers are full. Commands are taken only while idle; start 4,
// stop 3, write byte 24, read byte 25, send ack 3, read ack 4 slots.
`include "i2c_master_bit_engine_macros.svh"

module i2c_master_bit_engine
    import i2cbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tx_byte[7:0], ack_value[8], sda_in[9], zero [15:10]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // cmd_valid[0], func[3:1]
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
    // ack_received[12], zero [15:13]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic         r_in_valid;
    t_item        r_in_item;
    logic         r_out_valid;
    t_result      r_out;
    logic         advance;
    t_result      core_result;
    t_core_status core_status;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_item.cmd_valid <= i_s_axis_tuser[0];
            r_in_item.func      <= i_s_axis_tuser[3:1];
            r_in_item.tx_byte   <= i_s_axis_tdata[7:0];
            r_in_item.ack_value <= i_s_axis_tdata[8];
            r_in_item.sda_in    <= i_s_axis_tdata[9];
        end
    end

    i2cbe_slot_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (core_result),
        .o_status  (core_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.ack_received, r_out.rx_byte, r_out.done_res,
                              r_out.busy_res, r_out.sda_out, r_out.scl_out};

    `I2CBE_ASSERT_NEXT(a_hold_when_stalled, !advance, $stable(core_status), "sequencer moved without a slot")
    `I2CBE_ASSERT_NEXT(a_done_goes_idle, advance && core_result.done_res, !core_status.active, "engine still busy after done")
    `I2CBE_ASSERT_SAME(a_rx_only_on_done, r_out_valid && (r_out.rx_byte != 8'd0), r_out.done_res, "received byte shown without done")
    `I2CBE_ASSERT_SAME(a_idle_slot_zero, !core_status.active, core_status.slot == 5'd0, "slot count left over while idle")

endmodule

>>> tb/sv/i2c_master_bit_engine_checker.sv
`timescale 1ns / 1ps

module i2c_master_bit_engine_checker
    import i2cbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // tx_byte[7:0], ack_value[8], sda_in[9], zero [15:10]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // cmd_valid[0], func[3:1]
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
    // ack_received[12], zero [15:13]
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_fail_count,
    output int                    o_outstanding,
    output int                    o_compared,
    output int                    o_cmds_done
);

    t_result    slot_results_q[$];

    logic       eng_busy;
    t_cmd       eng_cmd;
    logic [4:0] eng_slot;
    logic [7:0] eng_shift;
    logic       eng_ack_latch;
    logic       eng_ack_drive;
    logic       eng_scl;
    logic       eng_sda;

    int         fail_cnt    = 0;
    int         pending_cnt = 0;
    int         compared    = 0;
    int         cmds_done   = 0;

    assign o_fail_count  = fail_cnt;
    assign o_outstanding = pending_cnt;
    assign o_compared    = compared;
    assign o_cmds_done   = cmds_done;

    function automatic t_result predict_slot(input t_item it);
        t_result    r;
        logic [4:0] ph;
        logic [4:0] len;
        r   = '0;
        len = 5'd4;
        if (!eng_busy && it.cmd_valid && it.func <= CMD_READ_ACK) begin
            eng_busy = 1'b1;
            eng_cmd  = t_cmd'(it.func);
            eng_slot = '0;
            if (eng_cmd == CMD_WRITE)
                eng_shift = it.tx_byte;
            if (eng_cmd == CMD_SEND_ACK)
                eng_ack_drive = it.ack_value;
        end
        if (eng_busy) begin
            case (eng_cmd)
                CMD_START: begin
                    if (eng_slot == 5'd0)      eng_sda = 1'b1;
                    else if (eng_slot == 5'd1) eng_scl = 1'b1;
                    else if (eng_slot == 5'd2) eng_sda = 1'b0;
                    else                       eng_scl = 1'b0;
                    len = 5'd4;
                end
                CMD_STOP: begin
                    if (eng_slot == 5'd0)      eng_sda = 1'b0;
                    else if (eng_slot == 5'd1) eng_scl = 1'b1;
                    else                       eng_sda = 1'b1;
                    len = 5'd3;
                end
                CMD_WRITE: begin
                    ph = eng_slot % 5'd3;
                    if (ph == 5'd0) begin
                        eng_sda = ((eng_shift & MSB_MASK) != 8'd0);
                    end else if (ph == 5'd1) begin
                        eng_scl = 1'b1;
                    end else begin
                        eng_scl   = 1'b0;
                        eng_shift = {eng_shift[6:0], 1'b0};
                    end
                    len = 5'd24;
                end
                CMD_READ: begin
                    if (eng_slot == 5'd0) begin
                        eng_sda   = 1'b1;
                        eng_shift = '0;
                    end else begin
                        ph = (eng_slot - 5'd1) % 5'd3;
                        if (ph == 5'd0)      eng_scl = 1'b1;
                        else if (ph == 5'd1) eng_shift = {eng_shift[6:0], it.sda_in};
                        else                 eng_scl = 1'b0;
                    end
                    len = 5'd25;
                end
                CMD_SEND_ACK: begin
                    if (eng_slot == 5'd0)      eng_sda = eng_ack_drive;
                    else if (eng_slot == 5'd1) eng_scl = 1'b1;
                    else                       eng_scl = 1'b0;
                    len = 5'd3;
                end
                default: begin
                    if (eng_slot == 5'd0)      eng_sda = 1'b1;
                    else if (eng_slot == 5'd1) eng_scl = 1'b1;
                    else if (eng_slot == 5'd2) eng_ack_latch = it.sda_in;
                    else                       eng_scl = 1'b0;
                    len = 5'd4;
                end
            endcase
            if (eng_slot + 5'd1 >= len) begin
                r.done_res = 1'b1;
                eng_busy   = 1'b0;
                if (eng_cmd == CMD_READ)
                    r.rx_byte = eng_shift;
                if (eng_cmd == CMD_READ_ACK)
                    r.ack_received = eng_ack_latch;
                eng_slot = '0;
            end else begin
                eng_slot = eng_slot + 5'd1;
            end
        end
        r.scl_out  = eng_scl;
        r.sda_out  = eng_sda;
        r.busy_res = eng_busy;
        return r;
    endfunction

    function automatic int check_field(input string name, input int unsigned want,
                                       input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_item   it;
        t_result got;
        t_result want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            eng_busy      = 1'b0;
            eng_cmd       = CMD_START;
            eng_slot      = '0;
            eng_shift     = '0;
            eng_ack_latch = 1'b0;
            eng_ack_drive = 1'b0;
            eng_scl       = 1'b1;
            eng_sda       = 1'b1;
            slot_results_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.scl_out      = i_m_tdata[0];
                got.sda_out      = i_m_tdata[1];
                got.busy_res     = i_m_tdata[2];
                got.done_res     = i_m_tdata[3];
                got.rx_byte      = i_m_tdata[11:4];
                got.ack_received = i_m_tdata[12];
                if (slot_results_q.size() == 0) begin
                    $error("result transfer with nothing expected: tdata %h", i_m_tdata);
                    errs++;
                end else begin
                    want = slot_results_q.pop_front();
                    errs += check_field("scl_out", want.scl_out, got.scl_out);
                    errs += check_field("sda_out", want.sda_out, got.sda_out);
                    errs += check_field("busy_res", want.busy_res, got.busy_res);
                    errs += check_field("done_res", want.done_res, got.done_res);
                    errs += check_field("rx_byte", want.rx_byte, got.rx_byte);
                    errs += check_field("ack_received", want.ack_received,
                                        got.ack_received);
                    compared <= compared + 1;
                    if (want.done_res)
                        cmds_done <= cmds_done + 1;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                it.cmd_valid = i_s_tuser[0];
                it.func      = i_s_tuser[3:1];
                it.tx_byte   = i_s_tdata[7:0];
                it.ack_value = i_s_tdata[8];
                it.sda_in    = i_s_tdata[9];
                slot_results_q.push_back(predict_slot(it));
            end
        end
        pending_cnt <= slot_results_q.size();
        fail_cnt    <= fail_cnt + errs;
    end

endmodule

>>> tb/sv/tb_i2c_master_bit_engine.sv
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine;
    import i2cbe_pkg::*;

    typedef enum logic [1:0] {
        PH_DIRECTED,
        PH_RANDOM,
        PH_HOLD,
        PH_CALM
    } t_stim_phase;

    localparam logic [2:0] FUNC_BAD_LO = 3'd6;
    localparam logic [2:0] FUNC_BAD_HI = 3'd7;
    localparam int         RANDOM_END  = 1010;
    localparam int         CALM_START  = 960;
    localparam int         HOLD_AT     = 350;
    localparam int         PAUSE_AT    = 650;
    localparam int         HOLD_CYCLES = 300;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  i_s_axis_tuser  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    int                    fail_count;
    int                    outstanding;
    int                    compared;
    int                    cmds_done;

    t_stim_phase           stim_phase = PH_DIRECTED;
    logic                  hold_done  = 1'b0;
    logic                  gaps_on    = 1'b1;
    int                    slots_sent = 0;

    always #4 i_clk = ~i_clk;

    i2c_master_bit_engine uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    i2c_master_bit_engine_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tuser     (i_s_axis_tuser),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_compared    (compared),
        .o_cmds_done   (cmds_done)
    );

    task automatic send_slot(input logic cv, input logic [2:0] fn, input logic [7:0] txb,
                             input logic ackv, input logic sda);
        int gap;
        if (gaps_on && stim_phase == PH_RANDOM && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, sda, ackv, txb};
        i_s_axis_tuser  <= {fn, cv};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        slots_sent++;
    endtask

    task automatic run_cmd(input t_cmd c, input logic [7:0] txb, input logic ackv);
        send_slot(1'b1, c, txb, ackv, 1'($urandom));
        repeat (int'(cmd_len(c)) - 1)
            send_slot(1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom),
                      1'($urandom));
    endtask

    task automatic idle_slots(input int n);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                send_slot(1'b1, $urandom_range(0, 1) ? FUNC_BAD_LO : FUNC_BAD_HI,
                          8'($urandom), 1'($urandom), 1'($urandom));
            else
                send_slot(1'b0, 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic i2c_transaction();
        int         rounds;
        logic [7:0] b;
        rounds  = $urandom_range(1, 3);
        gaps_on = ($urandom_range(0, 3) != 0);
        run_cmd(CMD_START, 8'($urandom), 1'($urandom));
        idle_slots($urandom_range(0, 2));
        repeat (rounds) begin
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 4))
                    0:       b = 8'hFF;
                    1:       b = 8'h00;
                    default: b = 8'($urandom);
                endcase
                run_cmd(CMD_WRITE, b, 1'($urandom));
                idle_slots($urandom_range(0, 2));
                run_cmd(CMD_READ_ACK, 8'($urandom), 1'($urandom));
            end else begin
                run_cmd(CMD_READ, 8'($urandom), 1'($urandom));
                idle_slots($urandom_range(0, 2));
                run_cmd(CMD_SEND_ACK, 8'($urandom), 1'($urandom));
            end
            idle_slots($urandom_range(0, 2));
        end
        run_cmd(CMD_STOP, 8'($urandom), 1'($urandom));
        idle_slots($urandom_range(0, 3));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 30))
            send_slot(1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom),
                      1'($urandom));
        idle_slots(25);
    endtask

    always begin : rx_side
        int n;
        if (stim_phase == PH_HOLD && !hold_done) begin
            i_m_axis_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_done = 1'b1;
        end else if (stim_phase != PH_CALM && $urandom_range(0, 4) == 0) begin
            i_m_axis_tready <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge i_clk);
        end else begin
            i_m_axis_tready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic hold_seen;
        logic paused;
        hold_seen = 1'b0;
        paused    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_slot(1'b0, CMD_START, 8'hFF, 1'b1, 1'b1);
        send_slot(1'b0, CMD_START, 8'h00, 1'b0, 1'b0);
        send_slot(1'b1, FUNC_BAD_LO, 8'h5A, 1'b0, 1'b1);
        send_slot(1'b1, FUNC_BAD_HI, 8'hA5, 1'b1, 1'b0);
        run_cmd(CMD_START, 8'h00, 1'b0);
        run_cmd(CMD_SEND_ACK, 8'hFF, 1'b1);
        run_cmd(CMD_SEND_ACK, 8'h00, 1'b0);
        run_cmd(CMD_READ_ACK, 8'h00, 1'b0);
        run_cmd(CMD_READ_ACK, 8'hFF, 1'b1);
        run_cmd(CMD_STOP, 8'h00, 1'b0);

        stim_phase = PH_RANDOM;
        while (slots_sent < RANDOM_END) begin
            if (!hold_seen && slots_sent >= HOLD_AT) begin
                stim_phase = PH_HOLD;
                while (!hold_done) i2c_transaction();
                stim_phase = PH_RANDOM;
                hold_seen  = 1'b1;
            end
            if (!paused && slots_sent >= PAUSE_AT) begin
                i_s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (outstanding != 0);
                paused = 1'b1;
            end
            if (slots_sent >= CALM_START)
                stim_phase = PH_CALM;
            if ($urandom_range(0, 6) == 0)
                noise_burst();
            else
                i2c_transaction();
        end

        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bus slots: directed edge cases, I2C transactions, noise,",
                 slots_sent);
        $display("a long output stall and a drain pause; %0d results checked, %0d done.",
                 compared, cmds_done);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
